// ===== hdl/hlpe_pkg.sv =====
package hlpe_pkg;

    // Strip geometry
    localparam int MAX_LEDS_DEF   = 256;
    localparam int BITS_PER_LED   = 24;
    localparam int LAST_BIT       = 23;
    localparam int CNT_W          = 5;

    // Field widths
    localparam int HUE_W          = 9;
    localparam int CHAN_W         = 8;
    localparam int LED_W          = 8;
    localparam int SLOT_W         = 13;
    localparam int DUTY_W         = 16;
    localparam int CFG_IDX_W      = 4;

    // Color arithmetic
    localparam int HUE_WRAP       = 360;
    localparam int DEG_PER_SECTOR = 60;
    localparam int CHAN_MAX       = 255;
    localparam int SECTOR_W       = 3;
    localparam int DIST_W         = 6;
    localparam int SCALED_W       = 22;
    // channel term is scaled by 255*60; the 8-bit channel is term / 15300
    localparam int CHAN_DIV       = 15300;
    // floor(2^30 / 15300): underestimates the quotient by at most one
    localparam int RECIP          = 70179;
    localparam int RECIP_W        = 17;
    localparam int RECIP_SHIFT    = 30;
    localparam int PROD_W         = SCALED_W + RECIP_W;

    // Queue between the color front end and the serializer
    localparam int QUEUE_DEPTH    = 2;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_DUTY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ONE_DUTY  = CFG_IDX_W'(1);

    localparam logic [DUTY_W-1:0] ZERO_DUTY_RST = DUTY_W'(29);
    localparam logic [DUTY_W-1:0] ONE_DUTY_RST  = DUTY_W'(58);

    // One converted LED request, as queued for serialization
    typedef struct packed {
        logic [3*CHAN_W-1:0] grb;
        logic [LED_W-1:0]    led;
        logic                list_end;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [DUTY_W-1:0] zero_duty;
        logic [DUTY_W-1:0] one_duty;
    } cfg_t;

endpackage

// ===== hdl/hlpe_front.sv =====
module hlpe_front #(
    parameter int MAX_LEDS = hlpe_pkg::MAX_LEDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hlpe_pkg::HUE_W-1:0]     hue,
    input  logic [hlpe_pkg::CHAN_W-1:0]    saturation,
    input  logic [hlpe_pkg::CHAN_W-1:0]    brightness,
    input  logic [hlpe_pkg::LED_W-1:0]     led_pos,
    input  logic                           list_end,
    input  hlpe_pkg::q_status_t            q_status,
    output logic                           push,
    output hlpe_pkg::item_t                push_item
);

    localparam int CW = hlpe_pkg::CHAN_W;
    localparam int SW = hlpe_pkg::SCALED_W;
    localparam int XW = hlpe_pkg::SECTOR_W;
    localparam int DW = hlpe_pkg::DIST_W;
    localparam int LW = hlpe_pkg::LED_W;
    localparam int MW = 2 * CW;
    localparam logic [hlpe_pkg::SLOT_W-1:0] LED_LIMIT = hlpe_pkg::SLOT_W'(MAX_LEDS);

    logic en;

    // ---- stage A input: hue wrap, sector and distance from sector edge
    logic [hlpe_pkg::HUE_W-1:0] h_wrap;
    logic [XW-1:0]              sector;
    logic [hlpe_pkg::HUE_W-1:0] sector_base;
    logic [DW-1:0]              r60;
    logic [DW-1:0]              hue_span;
    logic                       led_ok;

    always_comb
    begin
        if (hue >= hlpe_pkg::HUE_W'(hlpe_pkg::HUE_WRAP))
        begin
            h_wrap = hue - hlpe_pkg::HUE_W'(hlpe_pkg::HUE_WRAP);
        end
        else
        begin
            h_wrap = hue;
        end
    end

    always_comb
    begin
        priority if (h_wrap < hlpe_pkg::HUE_W'(60))
        begin
            sector      = XW'(0);
            sector_base = hlpe_pkg::HUE_W'(0);
        end
        else if (h_wrap < hlpe_pkg::HUE_W'(120))
        begin
            sector      = XW'(1);
            sector_base = hlpe_pkg::HUE_W'(60);
        end
        else if (h_wrap < hlpe_pkg::HUE_W'(180))
        begin
            sector      = XW'(2);
            sector_base = hlpe_pkg::HUE_W'(120);
        end
        else if (h_wrap < hlpe_pkg::HUE_W'(240))
        begin
            sector      = XW'(3);
            sector_base = hlpe_pkg::HUE_W'(180);
        end
        else if (h_wrap < hlpe_pkg::HUE_W'(300))
        begin
            sector      = XW'(4);
            sector_base = hlpe_pkg::HUE_W'(240);
        end
        else
        begin
            sector      = XW'(5);
            sector_base = hlpe_pkg::HUE_W'(300);
        end
    end

    // |(H/60 mod 2) - 1| * 60: odd sectors count up, even sectors count down
    assign r60      = DW'(h_wrap - sector_base);
    assign hue_span = sector[0] ? r60 : (DW'(hlpe_pkg::DEG_PER_SECTOR) - r60);
    assign led_ok   = ({(hlpe_pkg::SLOT_W - LW)'(0), led_pos} < LED_LIMIT);

    assign in_stall = !en;

    // ---- pipeline registers
    logic          a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    logic [CW-1:0] a_v_reg, a_s_reg;
    logic [XW-1:0] a_sector_reg, b_sector_reg, c_sector_reg, d_sector_reg, e_sector_reg;
    logic [DW-1:0] a_d_reg, b_d_reg;
    logic [LW-1:0] a_led_reg, b_led_reg, c_led_reg, d_led_reg, e_led_reg;
    logic          a_end_reg, b_end_reg, c_end_reg, d_end_reg, e_end_reg;
    logic [CW-1:0] b_v_reg, c_v_reg, d_v_reg, e_v_reg;
    logic [MW-1:0] b_vs_reg, b_mp_reg;
    logic [SW-1:0] c_y_reg;
    logic [CW-1:0] c_mc_reg, d_mc_reg, e_mc_reg;
    logic [SW-1:0] d_n_reg, e_n_reg;
    logic [CW-1:0] e_q0_reg;

    // stage C math: floor(x / 255) for x up to 255*255
    logic [MW:0]   mc_sum;
    // stage D/E math: x channel = floor(n / 15300) by reciprocal and one correction
    logic [hlpe_pkg::PROD_W-1:0] recip_prod;
    logic [SW-1:0]               rem;
    logic [CW-1:0]               xc;

    assign mc_sum     = (MW+1)'(b_mp_reg) + (MW+1)'(b_mp_reg >> CW) + (MW+1)'(1);
    assign recip_prod = hlpe_pkg::PROD_W'(d_n_reg)
                      * hlpe_pkg::PROD_W'(hlpe_pkg::RECIP);
    assign rem        = e_n_reg - (SW'(e_q0_reg) * SW'(hlpe_pkg::CHAN_DIV));
    assign xc         = e_q0_reg + CW'(rem >= SW'(hlpe_pkg::CHAN_DIV));

    // control: whole front advances together unless the last stage is blocked
    assign en = !(e_valid_reg && q_status.full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid && led_ok;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // A: classify
            a_v_reg      <= brightness;
            a_s_reg      <= saturation;
            a_sector_reg <= sector;
            a_d_reg      <= hue_span;
            a_led_reg    <= led_pos;
            a_end_reg    <= list_end;
            // B: v*s and v*(255-s)
            b_v_reg      <= a_v_reg;
            b_vs_reg     <= MW'(a_v_reg) * MW'(a_s_reg);
            b_mp_reg     <= MW'(a_v_reg) * MW'(CW'(hlpe_pkg::CHAN_MAX) - a_s_reg);
            b_sector_reg <= a_sector_reg;
            b_d_reg      <= a_d_reg;
            b_led_reg    <= a_led_reg;
            b_end_reg    <= a_end_reg;
            // C: v*s*d and the minimum channel
            c_v_reg      <= b_v_reg;
            c_y_reg      <= SW'(b_vs_reg) * SW'(b_d_reg);
            c_mc_reg     <= CW'(mc_sum >> CW);
            c_sector_reg <= b_sector_reg;
            c_led_reg    <= b_led_reg;
            c_end_reg    <= b_end_reg;
            // D: scaled x-channel term 15300*v - v*s*d
            d_n_reg      <= (SW'(hlpe_pkg::CHAN_DIV) * SW'(c_v_reg)) - c_y_reg;
            d_v_reg      <= c_v_reg;
            d_mc_reg     <= c_mc_reg;
            d_sector_reg <= c_sector_reg;
            d_led_reg    <= c_led_reg;
            d_end_reg    <= c_end_reg;
            // E: quotient estimate
            e_q0_reg     <= recip_prod[hlpe_pkg::RECIP_SHIFT +: CW];
            e_n_reg      <= d_n_reg;
            e_v_reg      <= d_v_reg;
            e_mc_reg     <= d_mc_reg;
            e_sector_reg <= d_sector_reg;
            e_led_reg    <= d_led_reg;
            e_end_reg    <= d_end_reg;
        end
    end

    // place max, mid and min channels by sector, pack as G,R,B
    logic [CW-1:0] ch_r, ch_g, ch_b;

    always_comb
    begin
        unique case (e_sector_reg)
            XW'(0):
            begin
                ch_r = e_v_reg;  ch_g = xc;       ch_b = e_mc_reg;
            end
            XW'(1):
            begin
                ch_r = xc;       ch_g = e_v_reg;  ch_b = e_mc_reg;
            end
            XW'(2):
            begin
                ch_r = e_mc_reg; ch_g = e_v_reg;  ch_b = xc;
            end
            XW'(3):
            begin
                ch_r = e_mc_reg; ch_g = xc;       ch_b = e_v_reg;
            end
            XW'(4):
            begin
                ch_r = xc;       ch_g = e_mc_reg; ch_b = e_v_reg;
            end
            default:
            begin
                ch_r = e_v_reg;  ch_g = e_mc_reg; ch_b = xc;
            end
        endcase
    end

    assign push               = e_valid_reg && !q_status.full;
    assign push_item.grb      = {ch_g, ch_r, ch_b};
    assign push_item.led      = e_led_reg;
    assign push_item.list_end = e_end_reg;

endmodule

// ===== hdl/hlpe_fifo.sv =====
module hlpe_fifo #(
    parameter int DEPTH = hlpe_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hlpe_pkg::item_t      push_item,
    input  logic                 pop,
    output hlpe_pkg::item_t      head,
    output hlpe_pkg::q_status_t  q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hlpe_pkg::item_t    mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == CNT_W'(0));
    assign head           = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue fill level out of range");

endmodule

// ===== hdl/hlpe_back.sv =====
module hlpe_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hlpe_pkg::cfg_t                 cfg,
    input  hlpe_pkg::item_t                head,
    input  hlpe_pkg::q_status_t            q_status,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hlpe_pkg::SLOT_W-1:0]    slot_index,
    output logic [hlpe_pkg::DUTY_W-1:0]    duty_word,
    output logic                           last_bit,
    output logic                           end_of_list
);

    localparam int NW = hlpe_pkg::CNT_W;
    localparam int SW = hlpe_pkg::SLOT_W;
    localparam logic [NW-1:0] CNT_LAST = NW'(hlpe_pkg::LAST_BIT);

    // current LED being serialized
    logic                         cur_valid_reg;
    logic [3*hlpe_pkg::CHAN_W-1:0] cur_grb_reg;
    logic [SW-1:0]                cur_base_reg;
    logic                         cur_end_reg;
    logic [NW-1:0]                cnt_reg;

    // output register
    logic                         out_valid_reg;
    logic [SW-1:0]                slot_index_reg;
    logic [hlpe_pkg::DUTY_W-1:0]  duty_word_reg;
    logic                         last_bit_reg;
    logic                         end_of_list_reg;

    logic load;
    logic word_last;
    logic bit_val;
    logic [SW-1:0] base_next;

    assign load      = !out_valid_reg || !out_stall;
    assign word_last = (cnt_reg == CNT_LAST);
    assign bit_val   = cur_grb_reg[CNT_LAST - cnt_reg];
    assign pop       = !q_status.empty && (!cur_valid_reg || (load && word_last));
    assign base_next = (SW'(head.led) * SW'(hlpe_pkg::BITS_PER_LED)) + SW'(1);

    // current-item control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            cnt_reg       <= '0;
        end
        else if (load && cur_valid_reg)
        begin
            if (word_last)
            begin
                cur_valid_reg <= 1'b0;
                cnt_reg       <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_grb_reg  <= head.grb;
            cur_base_reg <= base_next;
            cur_end_reg  <= head.list_end;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= cur_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && cur_valid_reg)
        begin
            slot_index_reg  <= cur_base_reg + SW'(cnt_reg);
            duty_word_reg   <= bit_val ? cfg.one_duty : cfg.zero_duty;
            last_bit_reg    <= word_last;
            end_of_list_reg <= word_last && cur_end_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign slot_index  = slot_index_reg;
    assign duty_word   = duty_word_reg;
    assign last_bit    = last_bit_reg;
    assign end_of_list = end_of_list_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST)
        else $error("bit counter out of range");

    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && end_of_list_reg |-> last_bit_reg)
        else $error("end of list flagged on a word that is not the last");

    a_no_gap_in_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_bit_reg && !out_stall |=> out_valid_reg)
        else $error("gap inside the words of one LED");

endmodule

// ===== hdl/hsv_led_pulse_encoder_top.sv =====
// HSV LED pulse encoder.
// Input channel (in_valid / in_stall): one request per LED carrying hue in
// degrees, saturation and brightness as n/255, the LED position and a list-end
// flag. A request is taken when in_valid is high and in_stall is low.
// Each request is converted to 8-bit G,R,B and serialized MSB first as 24
// output words (out_valid / out_stall): slot_index = led*24 + bit + 1, the
// zero or one duty word, last_bit on word 24, end_of_list on word 24 of a
// request that had list_end set. Requests with led_pos >= MAX_LEDS are
// dropped without output. Each request passes stages A to E and the queue
// before serialization. Throughput: one word per cycle while out_stall is low
// and words wait, set by the serializer and the single output word register.
// The five-stage color pipeline and the two-entry queue let following requests
// be taken while an LED is shifting out. Stalling the output holds the current
// word; the serializer then stops, the queue fills and in_stall rises. Reset
// empties the pipeline and queue and loads zero_duty = 29, one_duty = 58.
// The user must write config (cfg_valid / cfg_ready, always ready) only
// while idle; the block does not check it. Index 0 is zero_duty, 1 is one_duty.
module hsv_led_pulse_encoder_top #(
    parameter int MAX_LEDS = hlpe_pkg::MAX_LEDS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [hlpe_pkg::HUE_W-1:0]        hue,
    input  logic [hlpe_pkg::CHAN_W-1:0]       saturation,
    input  logic [hlpe_pkg::CHAN_W-1:0]       brightness,
    input  logic [hlpe_pkg::LED_W-1:0]        led_pos,
    input  logic                              list_end,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [hlpe_pkg::SLOT_W-1:0]       slot_index,
    output logic [hlpe_pkg::DUTY_W-1:0]       duty_word,
    output logic                              last_bit,
    output logic                              end_of_list,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hlpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hlpe_pkg::DUTY_W-1:0]       cfg_data
);

    hlpe_pkg::cfg_t       cfg_reg;
    hlpe_pkg::q_status_t  q_status;
    hlpe_pkg::item_t      push_item;
    hlpe_pkg::item_t      head;
    logic                 push;
    logic                 pop;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_duty <= hlpe_pkg::ZERO_DUTY_RST;
            cfg_reg.one_duty  <= hlpe_pkg::ONE_DUTY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hlpe_pkg::REG_ZERO_DUTY: cfg_reg.zero_duty <= cfg_data;
                hlpe_pkg::REG_ONE_DUTY:  cfg_reg.one_duty  <= cfg_data;
                default: ;
            endcase
        end
    end

    hlpe_front #(
        .MAX_LEDS (MAX_LEDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .led_pos    (led_pos),
        .list_end   (list_end),
        .q_status   (q_status),
        .push       (push),
        .push_item  (push_item)
    );

    hlpe_fifo #(
        .DEPTH (hlpe_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    hlpe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .slot_index  (slot_index),
        .duty_word   (duty_word),
        .last_bit    (last_bit),
        .end_of_list (end_of_list)
    );

endmodule
